/* rtl/core/prt_pkg.sv */
// Shared types and constants for the primitive root tester.
// Used by prt_modmul and primitive_root_test; no dependencies.
`timescale 1ns / 1ps

package prt_pkg;

  // Field width of modulus, candidate and every residue.
  localparam int unsigned DATA_W          = 12;
  // Default bitmap depth; moduli at or above it are rejected.
  localparam int unsigned PRT_MAX_MODULUS = 4096;
  // Bit counter of the modular multiplier.
  localparam int unsigned CNT_W           = $clog2(DATA_W);

  // Request to the shared modular multiplier: (a * b) mod m.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] m;
  } mm_req_t;

  // Answer of the multiplier; prod is valid while done is high.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] prod;
  } mm_rsp_t;

endpackage

/* rtl/core/prt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Self-contained; holds the bitmap of seen residues.
`timescale 1ns / 1ps

module prt_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/prt_modmul.sv */
// Bit-serial modular multiplier: one bit of b per cycle, double-and-add mod m.
// Depends on prt_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module prt_modmul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prt_pkg::mm_req_t req_i,
  output prt_pkg::mm_rsp_t rsp_o
);

  import prt_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] r_q, r_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] m_q, m_d;

  logic [DATA_W:0]   dbl;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] addend;

  // One step: r = (2r + bit*a) mod m, with r < m and a < m.
  always_comb begin
    dbl = {r_q, 1'b0};
    if (dbl >= {1'b0, m_q}) begin
      dbl = dbl - {1'b0, m_q};
    end
    addend = b_q[DATA_W-1] ? a_q : '0;
    sum    = dbl + {1'b0, addend};
    if (sum >= {1'b0, m_q}) begin
      sum = sum - {1'b0, m_q};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DATA_W - 1);
      r_d    = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      m_d    = req_i.m;
    end else if (busy_q) begin
      r_d = sum[DATA_W-1:0];
      b_d = {b_q[DATA_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule

/* rtl/core/primitive_root_test.sv */
// Primitive root tester: top level with the power-walk sequencer.
// Depends on prt_pkg, prt_ram (seen-residue bitmap) and prt_modmul.
`timescale 1ns / 1ps

// A request (modulus n, candidate i) is taken when start_i is high and busy_o
// is low. A rejected request (n below 2, n not below MaxModulus, i zero or
// not below n) answers with done_o in the next cycle and leaves busy_o low.
// A valid request first clears bitmap entries 0..n-1, one per cycle, then
// forms each power with the bit-serial multiplier, followed by handoff,
// bitmap read and check of that power. The walk ends at the first repeat,
// at a zero power or after n-2 powers. The answer is shown for one cycle
// with done_o and must be taken then; the receiver cannot stall it.
module primitive_root_test #(
  parameter int unsigned MaxModulus = prt_pkg::PRT_MAX_MODULUS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [prt_pkg::DATA_W-1:0] modulus_i,
  input  logic [prt_pkg::DATA_W-1:0] candidate_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic                      is_root_o,
  output logic                      bad_request_o
);

  import prt_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxModulus);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              done_q, done_d;
  logic              root_q, root_d;
  logic              bad_q, bad_d;
  logic [DATA_W-1:0] n_q, n_d;
  logic [DATA_W-1:0] c_q, c_d;
  logic [DATA_W-1:0] g_q, g_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [IdxW-1:0]   clr_q, clr_d;

  logic              req_bad;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic              ram_wdata;
  logic              ram_rdata;
  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;

  assign req_bad = (modulus_i < DATA_W'(2))
                || (32'(modulus_i) >= MaxModulus)
                || (candidate_i == '0)
                || (candidate_i >= modulus_i);

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    root_d    = root_q;
    bad_d     = bad_q;
    n_d       = n_q;
    c_d       = c_q;
    g_d       = g_q;
    rem_d     = rem_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = 1'b0;
    mm_req.start = 1'b0;
    mm_req.a     = g_q;
    mm_req.b     = c_q;
    mm_req.m     = n_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_bad) begin
            done_d = 1'b1;
            root_d = 1'b0;
            bad_d  = 1'b1;
          end else begin
            n_d     = modulus_i;
            c_d     = candidate_i;
            g_d     = DATA_W'(1);
            rem_d   = modulus_i - DATA_W'(2);
            clr_d   = '0;
            state_d = ST_CLEAR;
          end
        end
      end

      // Sweep entries 0..n-1; mark residue 1 as seen on the way.
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == IdxW'(1));
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == IdxW'(n_q - DATA_W'(1))) begin
          if (rem_q == '0) begin
            done_d  = 1'b1;
            root_d  = 1'b1;
            bad_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            mm_req.start = 1'b1;
            state_d      = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        if (mm_rsp.done) begin
          g_d     = mm_rsp.prod;
          state_d = ST_READ;
        end
      end

      // Bitmap read is in flight; data shows up in the next cycle.
      ST_READ: begin
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        if ((g_q == '0) || ram_rdata) begin
          done_d  = 1'b1;
          root_d  = 1'b0;
          bad_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = IdxW'(g_q);
          ram_wdata = 1'b1;
          rem_d     = rem_q - DATA_W'(1);
          if (rem_q == DATA_W'(1)) begin
            done_d  = 1'b1;
            root_d  = 1'b1;
            bad_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            mm_req.start = 1'b1;
            state_d      = ST_MUL;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    bad_q  <= bad_d;
    n_q    <= n_d;
    c_q    <= c_d;
    g_q    <= g_d;
    rem_q  <= rem_d;
    clr_q  <= clr_d;
  end

  prt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  prt_ram #(
    .Width (1),
    .Depth (MaxModulus)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (IdxW'(g_q)),
    .rdata_o (ram_rdata)
  );

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign is_root_o     = root_q;
  assign bad_request_o = bad_q;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for primitive_root_test: directed table, then random requests.
// Depends on prt_pkg and the primitive_root_test RTL; runs on its own, with no files read.
`timescale 1ns / 1ps

module testbench;
  import prt_pkg::*;

  localparam int unsigned StallLimit = 300000;
  localparam int unsigned NumRandom  = 80;
  localparam int unsigned NumRows    = 22;
  localparam logic        Typed      = 1'b1;
  localparam logic        Computed   = 1'b0;
  localparam int          PrimeList [12] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41};

  typedef struct packed {
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] candidate;
    logic              is_root;
    logic              bad_request;
  } verdict_t;

  typedef struct packed {
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] candidate;
    logic              typed;
    logic              is_root;
    logic              bad_request;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic [DATA_W-1:0] modulus_i;
  logic [DATA_W-1:0] candidate_i;
  logic              busy_o;
  logic              done_o;
  logic              is_root_o;
  logic              bad_request_o;

  verdict_t    pending_verdicts [$];
  verdict_t    oldest;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned answers_checked;
  int unsigned roots_seen;
  int unsigned rejects_seen;
  int unsigned idle_cycles;

  // modulus, candidate, typed/computed, is_root, bad_request
  row_t directed_rows [NumRows];

  primitive_root_test i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .modulus_i    (modulus_i),
    .candidate_i  (candidate_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .is_root_o    (is_root_o),
    .bad_request_o(bad_request_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Walk i^1 .. i^(n-2) mod n and stop at zero or the first residue seen twice.
  function automatic verdict_t judge_primitive_root(logic [DATA_W-1:0] n,
                                                    logic [DATA_W-1:0] c);
    bit          seen [PRT_MAX_MODULUS];
    int unsigned power;
    int unsigned k;
    verdict_t    v;
    v.modulus     = n;
    v.candidate   = c;
    v.is_root     = 1'b0;
    v.bad_request = 1'b0;
    if (n < 2 || int'(n) >= PRT_MAX_MODULUS || c == 0 || c >= n) begin
      v.bad_request = 1'b1;
      return v;
    end
    seen[1]   = 1'b1;
    power     = 1;
    v.is_root = 1'b1;
    for (k = 1; k + 2 <= n; k++) begin
      power = (power * c) % n;
      if (power == 0 || seen[power]) begin
        v.is_root = 1'b0;
        break;
      end
      seen[power] = 1'b1;
    end
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // Call at a falling edge; returns at a falling edge once busy_o is low, with start_i still high.
  task automatic issue_request(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] c,
                               input logic typed, input logic root, input logic bad);
    verdict_t v;
    start_i     = 1'b1;
    modulus_i   = n;
    candidate_i = c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (typed) begin
      v.modulus     = n;
      v.candidate   = c;
      v.is_root     = root;
      v.bad_request = bad;
    end else begin
      v = judge_primitive_root(n, c);
    end
    pending_verdicts = {pending_verdicts, v};
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles != 0) begin
      start_i = 1'b0;
      repeat (cycles) begin
        modulus_i   = $urandom_range(4095);
        candidate_i = $urandom_range(4095);
        @(negedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    start_i = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  // Check each answer against the oldest outstanding request.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch($sformatf("answer root=%0b bad=%0b with no request outstanding",
                                is_root_o, bad_request_o));
      end else begin
        oldest = pending_verdicts.pop_front();
        answers_checked++;
        if (oldest.is_root) roots_seen++;
        if (oldest.bad_request) rejects_seen++;
        if (is_root_o !== oldest.is_root || bad_request_o !== oldest.bad_request) begin
          note_mismatch($sformatf("n=%0d i=%0d: expected root=%0b bad=%0b, got root=%0b bad=%0b",
                                  oldest.modulus, oldest.candidate, oldest.is_root,
                                  oldest.bad_request, is_root_o, bad_request_o));
        end
      end
    end
  end

  // Abort when no beat moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no beat for %0d cycles, %0d answers outstanding",
                 StallLimit, pending_verdicts.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] n;
    logic [DATA_W-1:0] c;
    int unsigned       r;
    int unsigned       s;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    modulus_i       = '0;
    candidate_i     = '0;
    mismatches      = 0;
    requests_sent   = 0;
    answers_checked = 0;
    roots_seen      = 0;
    rejects_seen    = 0;
    idle_cycles     = 0;
    directed_rows = '{
      '{12'd0,    12'd0,    Typed,    1'b0, 1'b1},
      '{12'd1,    12'd0,    Typed,    1'b0, 1'b1},
      '{12'd1,    12'd1,    Typed,    1'b0, 1'b1},
      '{12'd0,    12'd4095, Typed,    1'b0, 1'b1},
      '{12'd4095, 12'd0,    Typed,    1'b0, 1'b1},
      '{12'd4095, 12'd4095, Typed,    1'b0, 1'b1},
      '{12'd2,    12'd2,    Typed,    1'b0, 1'b1},
      '{12'd5,    12'd5,    Typed,    1'b0, 1'b1},
      '{12'd2,    12'd1,    Typed,    1'b1, 1'b0},
      '{12'd3,    12'd1,    Typed,    1'b0, 1'b0},
      '{12'd3,    12'd2,    Typed,    1'b1, 1'b0},
      '{12'd4,    12'd2,    Typed,    1'b0, 1'b0},
      '{12'd5,    12'd2,    Typed,    1'b1, 1'b0},
      '{12'd5,    12'd4,    Typed,    1'b0, 1'b0},
      '{12'd7,    12'd3,    Typed,    1'b1, 1'b0},
      '{12'd7,    12'd2,    Typed,    1'b0, 1'b0},
      '{12'd4,    12'd3,    Computed, 1'b0, 1'b0},
      '{12'd11,   12'd2,    Computed, 1'b0, 1'b0},
      '{12'd13,   12'd12,   Computed, 1'b0, 1'b0},
      '{12'd4095, 12'd4094, Computed, 1'b0, 1'b0},
      '{12'd4095, 12'd1,    Computed, 1'b0, 1'b0},
      '{12'd4093, 12'd2,    Computed, 1'b0, 1'b0}
    };
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      issue_request(directed_rows[i].modulus, directed_rows[i].candidate,
                    directed_rows[i].typed, directed_rows[i].is_root,
                    directed_rows[i].bad_request);
      hold_off(pick_gap());
    end
    drain_results();

    for (int i = 0; i < NumRandom; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        n = $urandom_range(4095);
        c = $urandom_range(4095);
      end else if (r < 16) begin
        n = $urandom_range(64, 2);
        c = ($urandom_range(1) != 0) ? 12'd0 : 12'($urandom_range(4095, n));
      end else begin
        s = $urandom_range(99);
        if (s < 3) n = $urandom_range(4095, 2048);
        else if (s < 18) n = $urandom_range(600, 65);
        else if (s < 50) n = PrimeList[$urandom_range(11)];
        else n = $urandom_range(64, 2);
        s = $urandom_range(9);
        if (s == 0) c = 1;
        else if (s == 1) c = n - 1;
        else c = $urandom_range(n - 1, 1);
      end
      issue_request(n, c, Computed, 1'b0, 1'b0);
      // Starve the block once mid-run so it goes fully idle.
      if (i == NumRandom / 2) drain_results();
      else hold_off(pick_gap());
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("summary: %0d requests, %0d answers checked (%0d roots, %0d rejected), %0d mismatches",
             requests_sent, answers_checked, roots_seen, rejects_seen, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
